// ===== src/rtq_pkg.sv =====
`timescale 1ns / 1ps

package rtq_pkg;

  localparam int QueueSlotsDef  = 4;
  localparam int ReportBytesDef = 64;
  localparam int CounterBitsDef = 32;

  localparam int NumCounters = 6;
  localparam int CfgIndexW   = 2;
  localparam int CfgDataW    = 8;

  localparam logic [CfgIndexW-1:0] CFG_RETRY_LIMIT  = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_INPUT_SOURCE = 2'd1;

  localparam logic [7:0] RETRY_LIMIT_RST  = 8'd3;
  localparam logic       INPUT_SOURCE_RST = 1'b1;

  localparam logic [2:0] CMD_PUSH     = 3'd0;
  localparam logic [2:0] CMD_NEXT     = 3'd1;
  localparam logic [2:0] CMD_COMMIT   = 3'd2;
  localparam logic [2:0] CMD_DISCARD  = 3'd3;
  localparam logic [2:0] CMD_READ_CNT = 3'd4;

  localparam logic [2:0] KIND_PUSH    = 3'd0;
  localparam logic [2:0] KIND_BYTE    = 3'd1;
  localparam logic [2:0] KIND_TURN    = 3'd2;
  localparam logic [2:0] KIND_COMMIT  = 3'd3;
  localparam logic [2:0] KIND_COUNTER = 3'd4;

  localparam int STAT_DROPPED      = 0;
  localparam int STAT_SENT         = 1;
  localparam int STAT_FAILED       = 2;
  localparam int STAT_INPUT_SENT   = 3;
  localparam int STAT_INPUT_DROP   = 4;
  localparam int STAT_BAD          = 5;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] reply_byte;
    logic       last_byte;
    logic       sent_ok;
    logic [2:0] counter_select;
  } rtq_cmd_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  result_kind;
    logic [7:0]  out_byte;
    logic        last_of_run;
    logic        accepted;
    logic [6:0]  reply_length;
    logic [2:0]  queued_replies;
    logic [31:0] counter_value;
  } rtq_result_t;

endpackage

// ===== src/reply_transmit_queue_with_retry_top.sv =====
`timescale 1ns / 1ps
// Single-result commands: result strobe the cycle after the start transaction, busy stays low.
// Next on a non-empty queue: the first byte follows the job FIFO, the back end's active register
// and the store read register, then one byte per cycle; busy holds until the last store read.
// Push, commit, discard and counter reads accept one transaction per cycle while busy is low.
// Results cannot be stalled. Reset clears control state and counters, loads the config defaults;
// the byte store and reply lengths are undefined until written.

module reply_transmit_queue_with_retry_top import rtq_pkg::*; #(
  parameter int QUEUE_SLOTS  = QueueSlotsDef,
  parameter int REPORT_BYTES = ReportBytesDef,
  parameter int COUNTER_BITS = CounterBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           command_i,
  input  logic [7:0]           reply_byte_i,
  input  logic                 last_byte_i,
  input  logic                 sent_ok_i,
  input  logic [2:0]           counter_select_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  output logic                 result_strobe_o,
  output logic [2:0]           result_kind_o,
  output logic [7:0]           out_byte_o,
  output logic                 last_of_run_o,
  output logic                 accepted_o,
  output logic [6:0]           reply_length_o,
  output logic [2:0]           queued_replies_o,
  output logic [31:0]          counter_value_o
);

  localparam int POS_W  = $clog2(REPORT_BYTES + 1);
  localparam int DEPTH  = QUEUE_SLOTS * REPORT_BYTES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int JOB_W  = ADDR_W + POS_W + 3;

  rtq_cmd_t          cmd;
  rtq_result_t       front_res, back_res, res;
  logic              take;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;
  logic              job_push, job_pop, job_valid, back_active;
  logic [JOB_W-1:0]  job_in, job_out;

  assign cmd.command        = command_i;
  assign cmd.reply_byte     = reply_byte_i;
  assign cmd.last_byte      = last_byte_i;
  assign cmd.sent_ok        = sent_ok_i;
  assign cmd.counter_select = counter_select_i;

  assign busy        = job_valid || back_active;
  assign take        = start && !busy;
  assign cfg_ready_o = 1'b1;

  rtq_front #(
    .QUEUE_SLOTS (QUEUE_SLOTS),
    .REPORT_BYTES(REPORT_BYTES),
    .COUNTER_BITS(COUNTER_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .cmd_i      (cmd),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .job_push_o (job_push),
    .job_o      (job_in),
    .result_o   (front_res)
  );

  rtq_job_fifo #(
    .WIDTH(JOB_W)
  ) u_job_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_in),
    .pop_i  (job_pop),
    .valid_o(job_valid),
    .data_o (job_out)
  );

  rtq_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  rtq_back #(
    .QUEUE_SLOTS (QUEUE_SLOTS),
    .REPORT_BYTES(REPORT_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_i      (job_out),
    .job_pop_o  (job_pop),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata),
    .active_o   (back_active),
    .result_o   (back_res)
  );

  assign res = back_res.valid ? back_res : front_res;

  assign result_strobe_o  = res.valid;
  assign result_kind_o    = res.result_kind;
  assign out_byte_o       = res.out_byte;
  assign last_of_run_o    = res.last_of_run;
  assign accepted_o       = res.accepted;
  assign reply_length_o   = res.reply_length;
  assign queued_replies_o = res.queued_replies;
  assign counter_value_o  = res.counter_value;

endmodule

// ===== src/rtq_ram.sv =====
`timescale 1ns / 1ps

module rtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/rtq_job_fifo.sv =====
`timescale 1ns / 1ps

module rtq_job_fifo #(
  parameter int WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] entry_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       fill_q, fill_d;

  assign valid_o = (fill_q != 2'd0);
  assign data_o  = entry_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (push_i && fill_q != 2'd2) begin
      wptr_d = ~wptr_q;
      fill_d = fill_d + 2'd1;
    end
    if (pop_i && valid_o) begin
      rptr_d = ~rptr_q;
      fill_d = fill_d - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && fill_q != 2'd2) begin
      entry_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== src/rtq_front.sv =====
`timescale 1ns / 1ps

module rtq_front import rtq_pkg::*; #(
  parameter int QUEUE_SLOTS  = QueueSlotsDef,
  parameter int REPORT_BYTES = ReportBytesDef,
  parameter int COUNTER_BITS = CounterBitsDef,
  localparam int SLOT_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1,
  localparam int CNT_W  = $clog2(QUEUE_SLOTS + 1),
  localparam int POS_W  = $clog2(REPORT_BYTES + 1),
  localparam int DEPTH  = QUEUE_SLOTS * REPORT_BYTES,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int JOB_W  = ADDR_W + POS_W + 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  rtq_cmd_t             cmd_i,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  output logic                 ram_we_o,
  output logic [ADDR_W-1:0]    ram_waddr_o,
  output logic [7:0]           ram_wdata_o,
  output logic                 job_push_o,
  output logic [JOB_W-1:0]     job_o,
  output rtq_result_t          result_o
);

  logic [SLOT_W-1:0]       head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [7:0]              retry_q, retry_d, retry_inc;
  logic                    pending_q, pending_d;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic                    rej_q, rej_d;
  logic [POS_W-1:0]        len_q [QUEUE_SLOTS];
  logic [POS_W-1:0]        len_d [QUEUE_SLOTS];
  logic [COUNTER_BITS-1:0] stat_q [NumCounters];
  logic [NumCounters-1:0]  inc;
  logic [7:0]              limit_q;
  logic                    src_q;
  rtq_result_t             res_q, res_d;
  logic                    full, over, taken;
  logic [SLOT_W-1:0]       head_nx, tail_nx;
  logic [COUNTER_BITS-1:0] sel_val;

  assign full    = (count_q >= CNT_W'(QUEUE_SLOTS));
  assign over    = (pos_q >= POS_W'(REPORT_BYTES));
  assign head_nx = (head_q == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : head_q + SLOT_W'(1);
  assign tail_nx = (tail_q == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : tail_q + SLOT_W'(1);
  assign retry_inc = retry_q + 8'd1;
  assign sel_val = (cmd_i.counter_select < 3'(NumCounters)) ?
                   stat_q[cmd_i.counter_select] : '0;

  assign ram_waddr_o = ADDR_W'(tail_q) * ADDR_W'(REPORT_BYTES) + ADDR_W'(pos_q);
  assign ram_wdata_o = cmd_i.reply_byte;
  assign job_o       = {ADDR_W'(head_q) * ADDR_W'(REPORT_BYTES), len_q[head_q],
                        3'(count_q)};
  assign result_o    = res_q;

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    retry_d   = retry_q;
    pending_d = pending_q;
    pos_d     = pos_q;
    rej_d     = rej_q;
    len_d     = len_q;
    inc       = '0;
    taken     = 1'b0;
    ram_we_o  = 1'b0;
    job_push_o = 1'b0;
    res_d     = '0;
    if (take_i) begin
      unique case (cmd_i.command)
        CMD_PUSH: begin
          if (full || over) begin
            rej_d = 1'b1;
          end else if (!rej_q) begin
            ram_we_o = 1'b1;
            pos_d    = pos_q + POS_W'(1);
            taken    = 1'b1;
          end
          if (cmd_i.last_byte) begin
            if (rej_d) begin
              inc[STAT_DROPPED] = 1'b1;
              taken = 1'b0;
            end else begin
              len_d[tail_q] = pos_d;
              tail_d  = tail_nx;
              count_d = count_q + CNT_W'(1);
              taken   = 1'b1;
            end
            pos_d = '0;
            rej_d = 1'b0;
          end
          res_d.valid       = 1'b1;
          res_d.result_kind = KIND_PUSH;
          res_d.last_of_run = 1'b1;
          res_d.accepted    = taken;
        end
        CMD_NEXT: begin
          if (count_q != '0) begin
            pending_d  = 1'b1;
            job_push_o = 1'b1;
          end else begin
            pending_d         = 1'b0;
            res_d.valid       = 1'b1;
            res_d.result_kind = KIND_TURN;
            res_d.last_of_run = 1'b1;
            res_d.accepted    = src_q;
          end
        end
        CMD_COMMIT: begin
          if (!pending_q) begin
            if (cmd_i.sent_ok) inc[STAT_INPUT_SENT] = 1'b1;
            else               inc[STAT_INPUT_DROP] = 1'b1;
          end else if (count_q != '0) begin
            if (cmd_i.sent_ok) begin
              inc[STAT_SENT] = 1'b1;
              head_d  = head_nx;
              count_d = count_q - CNT_W'(1);
              retry_d = '0;
            end else begin
              inc[STAT_FAILED] = 1'b1;
              retry_d = retry_inc;
              if (retry_inc >= limit_q) begin
                inc[STAT_DROPPED] = 1'b1;
                head_d  = head_nx;
                count_d = count_q - CNT_W'(1);
                retry_d = '0;
              end
            end
          end
          res_d.valid       = 1'b1;
          res_d.result_kind = KIND_COMMIT;
          res_d.last_of_run = 1'b1;
        end
        CMD_DISCARD: begin
          if (pending_q && count_q != '0) begin
            inc[STAT_BAD] = 1'b1;
            head_d  = head_nx;
            count_d = count_q - CNT_W'(1);
            retry_d = '0;
          end
        end
        CMD_READ_CNT: begin
          res_d.valid         = 1'b1;
          res_d.result_kind   = KIND_COUNTER;
          res_d.last_of_run   = 1'b1;
          res_d.counter_value = 32'(sel_val);
        end
        default: ;
      endcase
      res_d.queued_replies = 3'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      retry_q   <= '0;
      pending_q <= 1'b0;
      pos_q     <= '0;
      rej_q     <= 1'b0;
      limit_q   <= RETRY_LIMIT_RST;
      src_q     <= INPUT_SOURCE_RST;
      res_q     <= '0;
      for (int k = 0; k < NumCounters; k++) begin
        stat_q[k] <= '0;
      end
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      retry_q   <= retry_d;
      pending_q <= pending_d;
      pos_q     <= pos_d;
      rej_q     <= rej_d;
      res_q     <= res_d;
      for (int k = 0; k < NumCounters; k++) begin
        if (inc[k]) stat_q[k] <= stat_q[k] + COUNTER_BITS'(1);
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_RETRY_LIMIT:  limit_q <= cfg_data_i;
          CFG_INPUT_SOURCE: src_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
  end

endmodule

// ===== src/rtq_back.sv =====
`timescale 1ns / 1ps

module rtq_back import rtq_pkg::*; #(
  parameter int QUEUE_SLOTS  = QueueSlotsDef,
  parameter int REPORT_BYTES = ReportBytesDef,
  localparam int POS_W  = $clog2(REPORT_BYTES + 1),
  localparam int DEPTH  = QUEUE_SLOTS * REPORT_BYTES,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int JOB_W  = ADDR_W + POS_W + 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  logic [JOB_W-1:0]  job_i,
  output logic              job_pop_o,
  output logic              ram_re_o,
  output logic [ADDR_W-1:0] ram_raddr_o,
  input  logic [7:0]        ram_rdata_i,
  output logic              active_o,
  output rtq_result_t       result_o
);

  logic              active_q, active_d;
  logic [POS_W-1:0]  idx_q, idx_d, idx_inc;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [POS_W-1:0]  n_q, n_d;
  logic [2:0]        qc_q, qc_d;
  logic              s1_valid_q, s1_last_q;
  logic [POS_W-1:0]  s1_len_q;
  logic [2:0]        s1_qc_q;
  logic              last_read;

  assign idx_inc     = idx_q + POS_W'(1);
  assign last_read   = (idx_inc == n_q);
  assign job_pop_o   = !active_q && job_valid_i;
  assign ram_re_o    = active_q;
  assign ram_raddr_o = base_q + ADDR_W'(idx_q);
  assign active_o    = active_q;

  always_comb begin
    active_d = active_q;
    idx_d    = idx_q;
    base_d   = base_q;
    n_d      = n_q;
    qc_d     = qc_q;
    if (job_pop_o) begin
      {base_d, n_d, qc_d} = job_i;
      idx_d    = '0;
      active_d = 1'b1;
    end else if (active_q) begin
      idx_d = idx_inc;
      if (last_read) active_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      active_q   <= active_d;
      s1_valid_q <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    base_q   <= base_d;
    n_q      <= n_d;
    qc_q     <= qc_d;
    s1_last_q <= last_read;
    s1_len_q <= n_q;
    s1_qc_q  <= qc_q;
  end

  always_comb begin
    result_o                = '0;
    result_o.valid          = s1_valid_q;
    result_o.result_kind    = KIND_BYTE;
    result_o.out_byte       = ram_rdata_i;
    result_o.last_of_run    = s1_last_q;
    result_o.reply_length   = 7'(s1_len_q);
    result_o.queued_replies = s1_qc_q;
  end

endmodule
